/* src/lpsm_pkg.sv */
// Shared constants and types of the logit penalty block with stop mask.
// Used by the top level; depends on nothing.
package lpsm_pkg;

	// Entries of the combined ban / history store.
	localparam int VOCAB_DEPTH = 32768;
	localparam int ADDR_W      = $clog2(VOCAB_DEPTH);

	// Request kinds carried on the item channel.
	localparam logic [1:0] REQ_BAN   = 2'd0;
	localparam logic [1:0] REQ_HIST  = 2'd1;
	localparam logic [1:0] REQ_LOGIT = 2'd2;

	// Configuration register indexes (byte address is four times the index).
	localparam int         PADDR_W           = 5;
	localparam logic [2:0] REG_VOCAB_SIZE    = 3'd0;
	localparam logic [2:0] REG_CUR_LEN       = 3'd1;
	localparam logic [2:0] REG_MIN_LEN       = 3'd2;
	localparam logic [2:0] REG_PENALTY       = 3'd3;
	localparam logic [2:0] REG_PENALTY_RECIP = 3'd4;
	localparam logic [2:0] REG_FREQUENCY     = 3'd5;
	localparam logic [2:0] REG_PRESENCE      = 3'd6;

	// Register reset values.
	localparam logic [15:0] VOCAB_SIZE_RST = 16'h8000;
	localparam logic [23:0] ONE_Q8_16      = 24'h01_0000;

	// Saturation limit of a history counter.
	localparam logic [15:0] CNT_MAX = 16'hFFFF;

	// One store entry: ban flag and history repeat count.
	typedef struct packed {
		logic        ban;
		logic [15:0] cnt;
	} entry_t;

endpackage

/* src/lpsm_if.sv */
// Channel interfaces of the logit penalty block: request items and result items.
// Both use a valid/ready handshake; they depend on nothing else.
interface lpsm_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] token_id;
	logic [14:0] token_index;
	logic [31:0] logit_in;
	logic [15:0] base_count;

	modport source (output valid, req_type, token_id, token_index, logit_in, base_count,
		input ready);
	modport sink (input valid, req_type, token_id, token_index, logit_in, base_count,
		output ready);
endinterface

interface lpsm_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] logit_out;
	logic [14:0] out_index;
	logic        is_last;

	modport source (output valid, logit_out, out_index, is_last, input ready);
	modport sink (input valid, logit_out, out_index, is_last, output ready);
endinterface

/* src/logit_penalty_with_stop_mask.sv */
// Top level of the logit penalty block with stop-token mask for one sequence.
// Depends on lpsm_pkg and on the channel interfaces in lpsm_if.sv.
//
// Usage: the item channel carries three kinds of transfer. Banned token ids
// (stop and end tokens) set a flag in the on-chip store, history token ids bump
// a saturating per-token count until the first negative id, and logit items
// stream the logits of one row, each with its prior repeat count. Only logit
// items produce a transfer on the result channel, one each, in order.
// A token transfer reads its store entry and writes it back; a token that has
// no effect does neither. A logit transfer reads and clears its store entry,
// then runs two multiplies, a rounding step and a saturating subtract, and its
// result is loaded into the output register from the final step. The
// sequencer walks its five steps (idle, read-modify-write, multiply, round,
// finish) for each logit and takes no new item until it is back in idle.
// The output register decouples the result channel: while it
// still holds an unread result the block keeps accepting and working, and it
// only waits in the final step if a second result is ready before the first
// has been taken.
// After reset the store is swept to zero, one entry per cycle, over all 32768
// entries; item ready stays low meanwhile. The APB port accepts writes at any
// time, but registers should only be changed while no item is in flight.
module logit_penalty_with_stop_mask (
	input  logic                              clk,
	input  logic                              arst_n,
	lpsm_item_if.sink                         item,
	lpsm_result_if.source                     result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lpsm_pkg::PADDR_W-1:0]      paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	localparam int AW = lpsm_pkg::ADDR_W;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RMW  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_RND  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [15:0]        vocab_size_q;
	logic signed [31:0] cur_len_q;
	logic [30:0]        min_len_q;
	logic [23:0]        penalty_q;
	logic [23:0]        recip_q;
	logic signed [23:0] freq_q;
	logic signed [23:0] pres_q;
	logic               cfg_wr;
	logic [2:0]         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vocab_size_q <= lpsm_pkg::VOCAB_SIZE_RST;
			cur_len_q    <= '0;
			min_len_q    <= '0;
			penalty_q    <= lpsm_pkg::ONE_Q8_16;
			recip_q      <= lpsm_pkg::ONE_Q8_16;
			freq_q       <= '0;
			pres_q       <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				lpsm_pkg::REG_VOCAB_SIZE:    vocab_size_q <= pwdata[15:0];
				lpsm_pkg::REG_CUR_LEN:       cur_len_q    <= pwdata;
				lpsm_pkg::REG_MIN_LEN:       min_len_q    <= pwdata[30:0];
				lpsm_pkg::REG_PENALTY:       penalty_q    <= pwdata[23:0];
				lpsm_pkg::REG_PENALTY_RECIP: recip_q      <= pwdata[23:0];
				lpsm_pkg::REG_FREQUENCY:     freq_q       <= pwdata[23:0];
				lpsm_pkg::REG_PRESENCE:      pres_q       <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			lpsm_pkg::REG_VOCAB_SIZE:    prdata = {16'd0, vocab_size_q};
			lpsm_pkg::REG_CUR_LEN:       prdata = cur_len_q;
			lpsm_pkg::REG_MIN_LEN:       prdata = {1'b0, min_len_q};
			lpsm_pkg::REG_PENALTY:       prdata = {8'd0, penalty_q};
			lpsm_pkg::REG_PENALTY_RECIP: prdata = {8'd0, recip_q};
			lpsm_pkg::REG_FREQUENCY:     prdata = {8'd0, freq_q};
			lpsm_pkg::REG_PRESENCE:      prdata = {8'd0, pres_q};
			default:                     prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Store and its clearing sweep
	// ------------------------------------------------------------------
	// Each entry holds the ban flag and the history count of one token. The
	// read port is used when an item that needs it is accepted; the write port
	// either clears during the sweep or writes back in the read-modify-write step.
	lpsm_pkg::entry_t store_mem [lpsm_pkg::VOCAB_DEPTH];
	lpsm_pkg::entry_t rd_entry_q;
	lpsm_pkg::entry_t wr_entry;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;
	logic             mem_we;
	logic             mem_re;

	logic             clr_busy_q;
	logic [AW-1:0]    clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == AW'(lpsm_pkg::VOCAB_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[wr_addr] <= wr_entry;
		end
		if (mem_re) begin
			rd_entry_q <= store_mem[rd_addr];
		end
	end

	// ------------------------------------------------------------------
	// Accept decode
	// ------------------------------------------------------------------
	logic [2:0]  state_q;
	logic        hist_stop_q;
	logic        accept;
	logic        cur_nonneg;
	logic        id_ok;
	logic        is_last_w;
	logic        in_store_w;
	logic        mask_w;
	logic [31:0] tid_w;
	logic [31:0] idx_w;
	logic        go_rmw;

	assign item.ready = (state_q == ST_IDLE) && !clr_busy_q;
	assign accept     = item.valid && item.ready;

	assign cur_nonneg = !cur_len_q[31];
	assign tid_w      = item.token_id;
	assign idx_w      = 32'(item.token_index);
	assign id_ok      = !tid_w[31] && (tid_w < 32'(vocab_size_q))
		&& (tid_w < 32'(lpsm_pkg::VOCAB_DEPTH));
	assign in_store_w = idx_w < 32'(lpsm_pkg::VOCAB_DEPTH);
	assign is_last_w  = (16'(item.token_index) + 16'd1) == vocab_size_q;
	// Masking applies while the sequence is shorter than its minimum length.
	assign mask_w     = cur_nonneg && (cur_len_q[30:0] < min_len_q);

	always_comb begin
		case (item.req_type)
			lpsm_pkg::REQ_BAN:   go_rmw = cur_nonneg && id_ok;
			lpsm_pkg::REQ_HIST:  go_rmw = cur_nonneg && !hist_stop_q && id_ok;
			lpsm_pkg::REQ_LOGIT: go_rmw = 1'b1;
			default:             go_rmw = 1'b0;
		endcase
	end

	assign rd_addr = (item.req_type == lpsm_pkg::REQ_LOGIT) ? idx_w[AW-1:0] : tid_w[AW-1:0];
	assign mem_re  = accept && go_rmw;

	// Item registers, held while the item is worked on.
	logic [1:0]        op_q;
	logic [AW-1:0]     addr_q;
	logic [14:0]       index_q;
	logic signed [31:0] logit_q;
	logic [15:0]       base_q;
	logic              last_q;
	logic              in_store_q;
	logic              mask_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= item.req_type;
			addr_q     <= rd_addr;
			index_q    <= item.token_index;
			logit_q    <= item.logit_in;
			base_q     <= item.base_count;
			last_q     <= is_last_w;
			in_store_q <= in_store_w;
			mask_q     <= mask_w;
		end
	end

	// The history stop flag is set by a negative history id and cleared by
	// the logit item that closes the row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_stop_q <= 1'b0;
		end else if (accept) begin
			if (item.req_type == lpsm_pkg::REQ_HIST && cur_nonneg && tid_w[31]) begin
				hist_stop_q <= 1'b1;
			end else if (item.req_type == lpsm_pkg::REQ_LOGIT && is_last_w) begin
				hist_stop_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Read-modify-write step
	// ------------------------------------------------------------------
	// Only one item is in flight, and its write-back lands before the next
	// item can be accepted, so a read never sees a stale entry.
	lpsm_pkg::entry_t upd_entry;

	always_comb begin
		upd_entry = rd_entry_q;
		case (op_q)
			lpsm_pkg::REQ_BAN: begin
				upd_entry.ban = 1'b1;
			end
			lpsm_pkg::REQ_HIST: begin
				if (rd_entry_q.cnt != lpsm_pkg::CNT_MAX) begin
					upd_entry.cnt = rd_entry_q.cnt + 16'd1;
				end
			end
			default: begin
				upd_entry = '0;
			end
		endcase
	end

	assign mem_we   = clr_busy_q
		|| (state_q == ST_RMW && (op_q != lpsm_pkg::REQ_LOGIT || in_store_q));
	assign wr_addr  = clr_busy_q ? clr_cnt_q : addr_q;
	assign wr_entry = clr_busy_q ? '0 : upd_entry;

	// ------------------------------------------------------------------
	// Logit datapath
	// ------------------------------------------------------------------
	// Stage 1: total count and the banned override.
	logic signed [31:0] x_s1;
	logic [16:0]        cnt_s1;
	logic               banned_w;
	logic [15:0]        hist_w;

	assign banned_w = in_store_q && rd_entry_q.ban;
	assign hist_w   = in_store_q ? rd_entry_q.cnt : 16'd0;

	always_ff @(posedge clk) begin
		if (state_q == ST_RMW) begin
			cnt_s1 <= 17'(base_q) + 17'(hist_w);
			x_s1   <= (banned_w && mask_q) ? 32'sh8000_0000 : logit_q;
		end
	end

	// Stage 2: magnitude times the penalty factor, count times frequency.
	logic [31:0]        mag_w;
	logic [23:0]        fac_w;
	logic [55:0]        prod_w;
	logic signed [41:0] cf_w;
	logic [55:0]        prod_s2;
	logic signed [41:0] cf_s2;
	logic signed [31:0] x_s2;
	logic               cnt_nz_s2;

	assign mag_w  = x_s1[31] ? (32'd0 - x_s1) : x_s1;
	// A positive logit shrinks by the reciprocal, a negative one grows by alpha.
	assign fac_w  = (!x_s1[31] && x_s1 != 32'sd0) ? recip_q : penalty_q;
	assign prod_w = mag_w * fac_w;
	assign cf_w   = $signed({1'b0, cnt_s1}) * freq_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_s2   <= prod_w;
			cf_s2     <= cf_w;
			x_s2      <= x_s1;
			cnt_nz_s2 <= cnt_s1 != 17'd0;
		end
	end

	// Stage 3: round to nearest with ties away from zero, restore the sign, and form
	// the additive penalty count*frequency + presence; a zero count skips both.
	logic [56:0]        rnd_sum;
	logic signed [41:0] p_ext;
	logic signed [41:0] r_s3;
	logic signed [42:0] pen_s3;

	assign rnd_sum = {1'b0, prod_s2} + 57'd32768;
	assign p_ext   = {1'b0, rnd_sum[56:16]};

	always_ff @(posedge clk) begin
		if (state_q == ST_RND) begin
			if (cnt_nz_s2) begin
				r_s3   <= x_s2[31] ? -p_ext : p_ext;
				pen_s3 <= 43'(cf_s2) + 43'(pres_q);
			end else begin
				r_s3   <= {{10{x_s2[31]}}, x_s2};
				pen_s3 <= '0;
			end
		end
	end

	// Stage 4: subtract and saturate into the output register.
	logic signed [43:0] diff_w;
	logic signed [31:0] sat_w;

	assign diff_w = 44'(r_s3) - 44'(pen_s3);

	always_comb begin
		if (diff_w > 44'sd2147483647) begin
			sat_w = 32'sh7FFF_FFFF;
		end else if (diff_w < -44'sd2147483648) begin
			sat_w = 32'sh8000_0000;
		end else begin
			sat_w = diff_w[31:0];
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	logic        out_valid_q;
	logic [31:0] logit_out_q;
	logic [14:0] out_index_q;
	logic        is_last_q;
	logic        out_load;

	assign out_load = (state_q == ST_FIN) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			logit_out_q <= sat_w;
			out_index_q <= index_q;
			is_last_q   <= last_q;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.logit_out = logit_out_q;
	assign result.out_index = out_index_q;
	assign result.is_last   = is_last_q;

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && go_rmw) begin
						state_q <= ST_RMW;
					end
				end
				ST_RMW: begin
					state_q <= (op_q == lpsm_pkg::REQ_LOGIT) ? ST_MUL : ST_IDLE;
				end
				ST_MUL: begin
					state_q <= ST_RND;
				end
				ST_RND: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_logit_to_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.req_type == lpsm_pkg::REQ_LOGIT) |=> state_q == ST_RMW)
		else $error("logit item did not enter the read-modify-write step");

	a_load_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> ($past(state_q) == ST_RND || $past(state_q) == ST_FIN))
		else $error("result loaded without passing through the rounding step");

	a_write_slot: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (clr_busy_q || state_q == ST_RMW))
		else $error("store written outside the sweep and the write-back step");

	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_busy_q) |-> $past(clr_cnt_q) == AW'(lpsm_pkg::VOCAB_DEPTH - 1))
		else $error("clearing sweep ended before the last entry");

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !mem_re)
		else $error("store read during the clearing sweep");

endmodule
